// File: design/lom_pkg.sv
// Shared types and constants for the limit order matcher.
// No dependencies; used by lom_book, limit_order_matcher and the testbench.
package lom_pkg;

  localparam int PRICE_W = 24;
  localparam int QTY_W = 16;
  localparam int BOOK_DEPTH_DEF = 32;

  // result kind, carried on out_tuser
  localparam logic KIND_TRADE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0] qty;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MRD,
    ST_MCMP,
    ST_INS,
    ST_SRD,
    ST_SCMP,
    ST_FRD,
    ST_FEMIT
  } state_t;

endpackage

// File: design/lom_book.sv
// One side of the order book: synchronous single-port-read, single-port-write memory.
// Depends on lom_pkg (entry_t).
module lom_book #(
  parameter int DEPTH = lom_pkg::BOOK_DEPTH_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic clk,
  input  logic rd_en,
  input  logic [AW-1:0] rd_addr,
  output lom_pkg::entry_t rd_data,
  input  logic wr_en,
  input  logic [AW-1:0] wr_addr,
  input  lom_pkg::entry_t wr_data
);

  lom_pkg::entry_t mem [DEPTH];
  lom_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/limit_order_matcher.sv
// Top level of the limit order matcher: sequencer, book pointers and result register.
// Depends on lom_pkg and lom_book (one instance per side).
//
//  channel | dir | tdata (low bit up)                               | tuser  | tlast
//  in_     | in  | price[23:0], quantity[39:24]                     | is_buy | -
//  out_    | out | trade_quantity, trade_price, best_bid, best_ask, | kind   | last
//          |     | rejected (bit 88), zero pad to 96                |        |
//
// Steps: an order passes accept, match check, insert check, status read and status
// emit; each trade adds a match read and compare, and so does a stop on price; a resting
// remainder adds a slot write (slot found at once) or a read and compare, plus a read and
// compare per entry shifted. The read-then-decide loop on the registered book reads sets this. Each side is a circular
// buffer, so a fill at the front only moves the head pointer; inserts shift from the tail.
// Reset (rst_n low, synchronous) empties both sides; memory contents need no clear.
// A result beat waits in the output register; the sequencer stalls only when it
// has a new beat and the register is still held by out_tready low.
module limit_order_matcher #(
  parameter int BOOK_DEPTH = lom_pkg::BOOK_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [39:0] in_tdata,   // price[23:0], quantity[39:24]
  input  logic in_tuser,          // is_buy
  output logic out_tvalid,
  input  logic out_tready,
  output logic [95:0] out_tdata,  // trade_quantity, trade_price, best_bid, best_ask, rejected
  output logic out_tuser,         // kind
  output logic out_tlast          // last
);

  localparam int AW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam int PW = lom_pkg::PRICE_W;
  localparam int QW = lom_pkg::QTY_W;

  // logical slot j of a side -> memory address, wrapping at the book depth
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] j);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(j);
    if (s >= (CW+1)'(BOOK_DEPTH)) begin
      s = s - (CW+1)'(BOOK_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  lom_pkg::state_t state_r, state_nxt;
  logic buy_r, buy_nxt;
  logic [PW-1:0] price_r, price_nxt;
  logic [QW-1:0] remain_r, remain_nxt;
  logic rej_r, rej_nxt;
  logic [AW-1:0] bhead_r, bhead_nxt, ahead_r, ahead_nxt;
  logic [CW-1:0] bcnt_r, bcnt_nxt, acnt_r, acnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [95:0] out_data_r, out_data_nxt;
  logic out_kind_r, out_kind_nxt;
  logic out_free;

  // book ports, viewed as own side and opposite side of the current order
  logic own_rd, op_rd, own_wr, op_wr;
  logic [AW-1:0] own_rd_a, op_rd_a, own_wr_a, op_wr_a;
  lom_pkg::entry_t own_wd, op_wd;
  lom_pkg::entry_t b_rd_data, a_rd_data, own_q, op_q;

  logic [AW-1:0] own_head, op_head;
  logic [CW-1:0] own_cnt, op_cnt;
  logic [PW-1:0] bidp, askp;
  logic [PW:0] psum;
  logic [QW-1:0] mq;
  logic worse;

  assign own_head = buy_r ? bhead_r : ahead_r;
  assign op_head  = buy_r ? ahead_r : bhead_r;
  assign own_cnt  = buy_r ? bcnt_r : acnt_r;
  assign op_cnt   = buy_r ? acnt_r : bcnt_r;
  assign own_q    = buy_r ? b_rd_data : a_rd_data;
  assign op_q     = buy_r ? a_rd_data : b_rd_data;

  assign bidp = buy_r ? price_r : op_q.price;
  assign askp = buy_r ? op_q.price : price_r;
  assign psum = (PW+1)'(bidp) + (PW+1)'(askp);
  assign mq   = (remain_r < op_q.qty) ? remain_r : op_q.qty;
  // resting entry ranks behind the new order
  assign worse = buy_r ? (own_q.price < price_r) : (own_q.price > price_r);

  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == lom_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    buy_nxt = buy_r;
    price_nxt = price_r;
    remain_nxt = remain_r;
    rej_nxt = rej_r;
    bhead_nxt = bhead_r;
    ahead_nxt = ahead_r;
    bcnt_nxt = bcnt_r;
    acnt_nxt = acnt_r;
    idx_nxt = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    out_kind_nxt = out_kind_r;
    own_rd = 1'b0;
    op_rd = 1'b0;
    own_wr = 1'b0;
    op_wr = 1'b0;
    own_rd_a = own_head;
    op_rd_a = op_head;
    own_wr_a = own_head;
    op_wr_a = op_head;
    own_wd = '{price: price_r, qty: remain_r};
    op_wd = '{price: op_q.price, qty: op_q.qty - mq};

    unique case (state_r)
      lom_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          buy_nxt = in_tuser;
          price_nxt = in_tdata[23:0];
          remain_nxt = in_tdata[39:24];
          rej_nxt = 1'b0;
          state_nxt = lom_pkg::ST_MRD;
        end
      end
      lom_pkg::ST_MRD: begin
        if (remain_r == '0 || op_cnt == '0) begin
          state_nxt = lom_pkg::ST_INS;
        end else begin
          op_rd = 1'b1;
          state_nxt = lom_pkg::ST_MCMP;
        end
      end
      lom_pkg::ST_MCMP: begin
        if (bidp < askp) begin
          state_nxt = lom_pkg::ST_INS;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt = lom_pkg::KIND_TRADE;
          out_data_nxt = {7'd0, 1'b0, 24'd0, 24'd0, psum[PW:1], mq};
          remain_nxt = remain_r - mq;
          if (op_q.qty == mq) begin
            // front order filled: advance the head
            if (buy_r) begin
              ahead_nxt = phys(ahead_r, CW'(1));
              acnt_nxt = acnt_r - 1'b1;
            end else begin
              bhead_nxt = phys(bhead_r, CW'(1));
              bcnt_nxt = bcnt_r - 1'b1;
            end
          end else begin
            op_wr = 1'b1;
          end
          state_nxt = lom_pkg::ST_MRD;
        end
      end
      lom_pkg::ST_INS: begin
        if (remain_r == '0) begin
          state_nxt = lom_pkg::ST_FRD;
        end else if (own_cnt == CW'(BOOK_DEPTH)) begin
          rej_nxt = 1'b1;
          state_nxt = lom_pkg::ST_FRD;
        end else begin
          idx_nxt = own_cnt;
          state_nxt = lom_pkg::ST_SRD;
        end
      end
      lom_pkg::ST_SRD: begin
        if (idx_r == '0) begin
          own_wr = 1'b1;
          own_wr_a = own_head;
          if (buy_r) bcnt_nxt = bcnt_r + 1'b1;
          else acnt_nxt = acnt_r + 1'b1;
          state_nxt = lom_pkg::ST_FRD;
        end else begin
          own_rd = 1'b1;
          own_rd_a = phys(own_head, idx_r - 1'b1);
          state_nxt = lom_pkg::ST_SCMP;
        end
      end
      lom_pkg::ST_SCMP: begin
        own_wr = 1'b1;
        own_wr_a = phys(own_head, idx_r);
        if (worse) begin
          // shift the entry one slot toward the tail
          own_wd = own_q;
          idx_nxt = idx_r - 1'b1;
          state_nxt = lom_pkg::ST_SRD;
        end else begin
          if (buy_r) bcnt_nxt = bcnt_r + 1'b1;
          else acnt_nxt = acnt_r + 1'b1;
          state_nxt = lom_pkg::ST_FRD;
        end
      end
      lom_pkg::ST_FRD: begin
        own_rd = 1'b1;
        op_rd = 1'b1;
        state_nxt = lom_pkg::ST_FEMIT;
      end
      lom_pkg::ST_FEMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt = lom_pkg::KIND_STATUS;
          out_data_nxt = {7'd0, rej_r,
                          (acnt_r != '0) ? a_rd_data.price : 24'd0,
                          (bcnt_r != '0) ? b_rd_data.price : 24'd0,
                          24'd0, 16'd0};
          state_nxt = lom_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lom_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lom_pkg::ST_IDLE;
      bhead_r <= '0;
      ahead_r <= '0;
      bcnt_r <= '0;
      acnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bhead_r <= bhead_nxt;
      ahead_r <= ahead_nxt;
      bcnt_r <= bcnt_nxt;
      acnt_r <= acnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    buy_r <= buy_nxt;
    price_r <= price_nxt;
    remain_r <= remain_nxt;
    rej_r <= rej_nxt;
    idx_r <= idx_nxt;
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
  end

  lom_book #(.DEPTH(BOOK_DEPTH), .AW(AW)) u_bid (
    .clk(clk),
    .rd_en(buy_r ? own_rd : op_rd),
    .rd_addr(buy_r ? own_rd_a : op_rd_a),
    .rd_data(b_rd_data),
    .wr_en(buy_r ? own_wr : op_wr),
    .wr_addr(buy_r ? own_wr_a : op_wr_a),
    .wr_data(buy_r ? own_wd : op_wd)
  );

  lom_book #(.DEPTH(BOOK_DEPTH), .AW(AW)) u_ask (
    .clk(clk),
    .rd_en(buy_r ? op_rd : own_rd),
    .rd_addr(buy_r ? op_rd_a : own_rd_a),
    .rd_data(a_rd_data),
    .wr_en(buy_r ? op_wr : own_wr),
    .wr_addr(buy_r ? op_wr_a : own_wr_a),
    .wr_data(buy_r ? op_wd : own_wd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_kind_r;
  assign out_tlast = out_kind_r;

endmodule

// File: tb/tb.sv
// Testbench for limit_order_matcher: directed order table, then random order flow.
// Depends on lom_pkg and the design; an in-line book predictor checks every result beat.
module tb;

  localparam int DEPTH = lom_pkg::BOOK_DEPTH_DEF;
  localparam int PW = lom_pkg::PRICE_W;
  localparam int QW = lom_pkg::QTY_W;

  typedef struct packed {
    logic kind;
    logic [QW-1:0] tq;
    logic [PW-1:0] tp;
    logic [PW-1:0] bb;
    logic [PW-1:0] ba;
    logic rej;
    logic last;
  } fill_t;

  typedef struct {
    bit buy;
    logic [PW-1:0] price;
    logic [QW-1:0] qty;
    bit has_exp;
    fill_t exp_status;
  } order_row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [39:0] in_tdata;
  logic out_tvalid, out_tready, out_tuser, out_tlast;
  logic [95:0] out_tdata;

  limit_order_matcher DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // shadow book, entry 0 is best
  logic [PW-1:0] bid_px[DEPTH], ask_px[DEPTH];
  logic [QW-1:0] bid_qt[DEPTH], ask_qt[DEPTH];
  int bid_n, ask_n;

  fill_t fills_due[$];
  fill_t last_status;
  int errors, n_orders, n_trades, n_rejects;
  int send_idle, recv_idle;   // percent
  bit hold_recv;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report(string what, logic [95:0] got, logic [95:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // work out the beats one order causes and queue them on fills_due
  task automatic predict_order(bit buy, logic [PW-1:0] price, logic [QW-1:0] qty);
    logic [QW-1:0] rem, mq;
    logic [PW-1:0] rp, bp, ap;
    logic [PW:0] sum;
    fill_t f;
    bit rej;
    int pos;
    rem = qty;
    rej = 0;
    forever begin
      if (rem == 0 || (buy ? ask_n : bid_n) == 0) break;
      rp = buy ? ask_px[0] : bid_px[0];
      bp = buy ? price : rp;
      ap = buy ? rp : price;
      if (bp < ap) break;
      mq = buy ? ((rem < ask_qt[0]) ? rem : ask_qt[0]) : ((rem < bid_qt[0]) ? rem : bid_qt[0]);
      sum = {1'b0, bp} + {1'b0, ap};
      f = '0;
      f.kind = lom_pkg::KIND_TRADE;
      f.tq = mq;
      f.tp = sum[PW:1];
      fills_due.insert(fills_due.size(), f);
      n_trades++;
      rem -= mq;
      if (buy) begin
        if (ask_qt[0] == mq) begin
          for (int i = 1; i < ask_n; i++) begin ask_px[i-1] = ask_px[i]; ask_qt[i-1] = ask_qt[i]; end
          ask_n--;
        end else ask_qt[0] -= mq;
      end else begin
        if (bid_qt[0] == mq) begin
          for (int i = 1; i < bid_n; i++) begin bid_px[i-1] = bid_px[i]; bid_qt[i-1] = bid_qt[i]; end
          bid_n--;
        end else bid_qt[0] -= mq;
      end
    end
    if (rem != 0) begin
      if (buy) begin
        if (bid_n >= DEPTH) rej = 1;
        else begin
          pos = 0;
          while (pos < bid_n && !(bid_px[pos] < price)) pos++;
          for (int i = bid_n; i > pos; i--) begin bid_px[i] = bid_px[i-1]; bid_qt[i] = bid_qt[i-1]; end
          bid_px[pos] = price; bid_qt[pos] = rem; bid_n++;
        end
      end else begin
        if (ask_n >= DEPTH) rej = 1;
        else begin
          pos = 0;
          while (pos < ask_n && !(ask_px[pos] > price)) pos++;
          for (int i = ask_n; i > pos; i--) begin ask_px[i] = ask_px[i-1]; ask_qt[i] = ask_qt[i-1]; end
          ask_px[pos] = price; ask_qt[pos] = rem; ask_n++;
        end
      end
    end
    if (rej) n_rejects++;
    f = '0;
    f.kind = lom_pkg::KIND_STATUS;
    f.bb = bid_n > 0 ? bid_px[0] : '0;
    f.ba = ask_n > 0 ? ask_px[0] : '0;
    f.rej = rej;
    f.last = 1'b1;
    fills_due.insert(fills_due.size(), f);
  endtask

  // one order beat: optional idle gap, then hold valid until accepted;
  // valid stays up afterwards so the next order can follow back to back
  task automatic send_order(bit buy, logic [PW-1:0] price, logic [QW-1:0] qty);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= buy;
    in_tdata <= {qty, price};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_order(buy, price, qty);
    n_orders++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (fills_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold when asked
  initial begin
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      out_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end
  end

  // checker: compare each accepted beat with the oldest expectation
  always @(posedge clk) begin
    fill_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '0;
      got.kind = out_tuser;
      got.tq = out_tdata[15:0];
      got.tp = out_tdata[39:16];
      got.bb = out_tdata[63:40];
      got.ba = out_tdata[87:64];
      got.rej = out_tdata[88];
      got.last = out_tlast;
      if (got.kind == lom_pkg::KIND_STATUS) last_status = got;
      if (fills_due.size() == 0) report("unexpected beat", 96'(got), '0);
      else begin
        want = fills_due.pop_front();
        if (got.kind != want.kind) report("kind", 96'(got.kind), 96'(want.kind));
        if (got.tq != want.tq) report("trade_quantity", 96'(got.tq), 96'(want.tq));
        if (got.tp != want.tp) report("trade_price", 96'(got.tp), 96'(want.tp));
        if (got.bb != want.bb) report("best_bid", 96'(got.bb), 96'(want.bb));
        if (got.ba != want.ba) report("best_ask", 96'(got.ba), 96'(want.ba));
        if (got.rej != want.rej) report("rejected", 96'(got.rej), 96'(want.rej));
        if (got.last != want.last) report("last", 96'(got.last), 96'(want.last));
        if (out_tdata[95:89] != 0) report("pad", out_tdata, '0);
      end
    end
  end

  order_row_t orders_directed[$];

  function automatic fill_t status_of(logic [PW-1:0] bb, logic [PW-1:0] ba, bit rej);
    fill_t f;
    f = '0;
    f.kind = lom_pkg::KIND_STATUS; f.bb = bb; f.ba = ba; f.rej = rej; f.last = 1'b1;
    return f;
  endfunction

  task automatic add_row(bit buy, logic [PW-1:0] price, logic [QW-1:0] qty, bit chk, fill_t st);
    order_row_t r;
    r.buy = buy; r.price = price; r.qty = qty; r.has_exp = chk; r.exp_status = st;
    orders_directed.insert(orders_directed.size(), r);
  endtask

  // random order around a mid, mostly crossing-capable
  task automatic random_order(int mid);
    bit buy;
    int px, q;
    buy = $urandom_range(1);
    case ($urandom_range(9))
      0: px = $urandom_range(24'hFFFFFF);
      1: px = buy ? 24'hFFFFFF : 0;
      default: px = mid + $urandom_range(16) - 8;
    endcase
    case ($urandom_range(9))
      0: q = $urandom_range(16'hFFFF);
      1: q = 0;
      default: q = $urandom_range(40, 1);
    endcase
    send_order(buy, PW'(px), QW'(q));
  endtask

  initial begin
    fill_t none;
    none = '0;
    rst_n = 0; in_tvalid = 0; in_tuser = 0; in_tdata = '0; hold_recv = 0;
    errors = 0; n_orders = 0; n_trades = 0; n_rejects = 0;
    bid_n = 0; ask_n = 0; last_status = '0;
    send_idle = 30; recv_idle = 66;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero qty on empty book, extremes of price and qty, a cross, price zero
    add_row(1, 24'd100, 16'd0, 1, status_of(24'd0, 24'd0, 1'b0));
    add_row(0, 24'hFFFFFF, 16'hFFFF, 1, status_of(24'd0, 24'hFFFFFF, 1'b0));
    add_row(1, 24'd0, 16'd5, 1, status_of(24'd0, 24'hFFFFFF, 1'b0));
    add_row(1, 24'hFFFFFF, 16'hFFFF, 0, none);      // fills the top ask exactly
    add_row(0, 24'd0, 16'd3, 0, none);                // hits price-zero bid
    add_row(0, 24'd0, 16'd9, 0, none);                // empties bids, rests at 0
    add_row(1, 24'd50, 16'd1, 0, none);
    add_row(1, 24'd50, 16'd2, 0, none);               // trades with the ask resting at 0
    add_row(0, 24'd49, 16'd2, 0, none);
    add_row(1, 24'hFFFFFF, 16'd0, 0, none);
    add_row(0, 24'h800000, 16'h8000, 0, none);
    add_row(1, 24'hFFFFFF, 16'hFFFF, 0, none);        // sweeps several asks
    foreach (orders_directed[i]) begin
      send_order(orders_directed[i].buy, orders_directed[i].price, orders_directed[i].qty);
      if (orders_directed[i].has_exp) begin
        drain();
        if (last_status != orders_directed[i].exp_status)
          report("table status", 96'(last_status), 96'(orders_directed[i].exp_status));
      end
    end
    drain();

    // fill one side to the limit for the full-side reject
    for (int i = 0; i < DEPTH + 3; i++) send_order(1, PW'(1000 + i), 16'd1);
    drain();
    // long receiver hold while orders keep arriving
    hold_recv = 1;
    fork
      begin repeat (400) @(posedge clk); hold_recv = 0; end
      begin
        for (int i = 0; i < 6; i++) send_order(0, PW'(1030 - i), 16'd2);
        in_tvalid <= 1'b0;
      end
    join
    drain();

    // random phases with the three idle profiles
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 30 : (ph == 1 ? 66 : 0);
      recv_idle = ph == 0 ? 66 : (ph == 1 ? 30 : 0);
      for (int i = 0; i < 19; i++) random_order(1000 + ph * 5);
      drain();
    end

    $display("covered %0d orders, %0d trades, %0d rejects", n_orders, n_trades, n_rejects);
    $display("mismatches seen: %0d", errors);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
